FILE: src/bst_pkg.sv
package bst_pkg;

   localparam int TREE_SLOTS = 63;
   localparam int IDX_W      = $clog2(TREE_SLOTS);
   localparam int NODE_W     = IDX_W + 2;
   localparam int CNT_W      = IDX_W + 1;
   localparam int KEY_W      = 32;
   localparam int SLOT_W     = 6;

   // request kinds
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_SEARCH = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_DUP  = 2'd3;

   // datapath operations
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_PLACE     = 4'd2;
   localparam logic [3:0] OP_RD_NODE   = 4'd3;
   localparam logic [3:0] OP_DESCEND   = 4'd4;
   localparam logic [3:0] OP_REM_CLEAR = 4'd5;
   localparam logic [3:0] OP_SUCC_LEFT = 4'd6;
   localparam logic [3:0] OP_RD_S      = 4'd7;
   localparam logic [3:0] OP_SUCC_COPY = 4'd8;
   localparam logic [3:0] OP_RD_G      = 4'd9;
   localparam logic [3:0] OP_GATH_WR   = 4'd10;
   localparam logic [3:0] OP_CLIMB     = 4'd11;
   localparam logic [3:0] OP_RD_J      = 4'd12;
   localparam logic [3:0] OP_REIN_LD   = 4'd13;
   localparam logic [3:0] OP_RSP       = 4'd14;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [KEY_W-1:0] key_value;
   } bst_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot_index;
   } bst_rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic       set_res;
      logic [1:0] res_status;
      logic       res_node;
   } bst_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       node_oob;
      logic       node_p;
      logic       key_eq;
      logic       n_right_p;
      logic       n_left_p;
      logic       s_left_p;
      logic       g_left_p;
      logic       g_right_p;
      logic       g_is_root;
      logic       g_sib_p;
      logic       j_done;
   } bst_stat_type;

endpackage

FILE: src/bst_ram.sv
module bst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bst_datapath.sv
module bst_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bst_pkg::bst_req_type  req_data,
   input  bst_pkg::bst_cmd_type  cmd,
   output bst_pkg::bst_stat_type stat,
   output bst_pkg::bst_rsp_type  rsp_data
);

   localparam int S  = bst_pkg::TREE_SLOTS;
   localparam int IW = bst_pkg::IDX_W;
   localparam int NW = bst_pkg::NODE_W;
   localparam int CW = bst_pkg::CNT_W;
   localparam int KW = bst_pkg::KEY_W;

   function automatic logic present(input logic [NW-1:0] idx, input logic [S-1:0] v);
      logic in_range;
      in_range = (idx < NW'(S));
      return in_range && v[idx[IW-1:0]];
   endfunction

   logic [S-1:0]  valid_ff, valid_in;
   logic [1:0]    kind_ff, kind_in;
   logic [KW-1:0] wkey_ff, wkey_in;
   logic [NW-1:0] node_ff, node_in;
   logic [NW-1:0] s_ff, s_in;
   logic [NW-1:0] g_ff, g_in;
   logic [NW-1:0] root_ff, root_in;
   logic [NW-1:0] start_ff, start_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] j_ff, j_in;
   logic [1:0]    res_st_ff, res_st_in;
   logic [bst_pkg::SLOT_W-1:0] res_slot_ff, res_slot_in;
   bst_pkg::bst_rsp_type rsp_ff, rsp_in;

   logic [NW-1:0] node_l, node_r, s_l, g_l, g_r, g_sib, g_up;
   logic [KW-1:0] tree_rd, scr_rd, tree_wdata;
   logic [IW-1:0] tree_raddr, tree_waddr;
   logic          tree_we, scr_we;
   logic          key_lt;

   // child, sibling and parent indexes, and the key compare
   assign node_l = (node_ff << 1) + NW'(1);
   assign node_r = (node_ff << 1) + NW'(2);
   assign s_l    = (s_ff << 1) + NW'(1);
   assign g_l    = (g_ff << 1) + NW'(1);
   assign g_r    = (g_ff << 1) + NW'(2);
   assign g_sib  = g_ff + NW'(1);
   assign g_up   = (g_ff - NW'(1)) >> 1;
   assign key_lt = $signed(wkey_ff) < $signed(tree_rd);

   // status toward the controller
   always_comb begin
      stat.kind      = kind_ff;
      stat.node_oob  = (node_ff >= NW'(S));
      stat.node_p    = present(node_ff, valid_ff);
      stat.key_eq    = (tree_rd == wkey_ff);
      stat.n_right_p = present(node_r, valid_ff);
      stat.n_left_p  = present(node_l, valid_ff);
      stat.s_left_p  = present(s_l, valid_ff);
      stat.g_left_p  = present(g_l, valid_ff);
      stat.g_right_p = present(g_r, valid_ff);
      stat.g_is_root = (g_ff == root_ff);
      stat.g_sib_p   = g_ff[0] && present(g_sib, valid_ff);
      stat.j_done    = (j_ff >= cnt_ff);
   end

   // memory port selection
   always_comb begin
      case (cmd.op)
         bst_pkg::OP_RD_S: tree_raddr = s_ff[IW-1:0];
         bst_pkg::OP_RD_G: tree_raddr = g_ff[IW-1:0];
         default:          tree_raddr = node_ff[IW-1:0];
      endcase
      tree_we    = (cmd.op == bst_pkg::OP_PLACE) || (cmd.op == bst_pkg::OP_SUCC_COPY);
      tree_waddr = node_ff[IW-1:0];
      tree_wdata = (cmd.op == bst_pkg::OP_PLACE) ? wkey_ff : tree_rd;
      scr_we     = (cmd.op == bst_pkg::OP_GATH_WR);
   end

   // next-state of the datapath registers
   always_comb begin
      valid_in    = valid_ff;
      kind_in     = kind_ff;
      wkey_in     = wkey_ff;
      node_in     = node_ff;
      s_in        = s_ff;
      g_in        = g_ff;
      root_in     = root_ff;
      start_in    = start_ff;
      cnt_in      = cnt_ff;
      j_in        = j_ff;
      res_st_in   = res_st_ff;
      res_slot_in = res_slot_ff;
      rsp_in      = rsp_ff;
      case (cmd.op)
         bst_pkg::OP_LOAD: begin
            kind_in = req_data.kind;
            wkey_in = req_data.key_value;
            node_in = '0;
         end
         bst_pkg::OP_PLACE: begin
            valid_in[node_ff[IW-1:0]] = 1'b1;
         end
         bst_pkg::OP_DESCEND: begin
            node_in = key_lt ? node_l : node_r;
         end
         bst_pkg::OP_REM_CLEAR: begin
            valid_in[node_ff[IW-1:0]] = 1'b0;
            s_in     = node_r;
            root_in  = node_l;
            g_in     = node_l;
            start_in = node_ff;
            cnt_in   = '0;
            j_in     = '0;
         end
         bst_pkg::OP_SUCC_LEFT: begin
            s_in = s_l;
         end
         bst_pkg::OP_SUCC_COPY: begin
            valid_in[node_ff[IW-1:0]] = 1'b1;
            root_in  = s_ff;
            g_in     = s_ff;
            start_in = s_ff;
            cnt_in   = '0;
            j_in     = CW'(1);
         end
         bst_pkg::OP_GATH_WR: begin
            valid_in[g_ff[IW-1:0]] = 1'b0;
            cnt_in = cnt_ff + CW'(1);
            if (present(g_l, valid_ff)) begin
               g_in = g_l;
            end else if (present(g_r, valid_ff)) begin
               g_in = g_r;
            end
         end
         bst_pkg::OP_CLIMB: begin
            g_in = (g_ff[0] && present(g_sib, valid_ff)) ? g_sib : g_up;
         end
         bst_pkg::OP_REIN_LD: begin
            wkey_in = scr_rd;
            node_in = start_ff;
            j_in    = j_ff + CW'(1);
         end
         bst_pkg::OP_RSP: begin
            rsp_in.status     = res_st_ff;
            rsp_in.slot_index = res_slot_ff;
         end
         default: begin
         end
      endcase
      if (cmd.set_res) begin
         res_st_in   = cmd.res_status;
         res_slot_in = cmd.res_node ? bst_pkg::SLOT_W'(node_ff) : '0;
      end
   end

   // clear presence bits under reset, payload without reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      kind_ff     <= kind_in;
      wkey_ff     <= wkey_in;
      node_ff     <= node_in;
      s_ff        <= s_in;
      g_ff        <= g_in;
      root_ff     <= root_in;
      start_ff    <= start_in;
      cnt_ff      <= cnt_in;
      j_ff        <= j_in;
      res_st_ff   <= res_st_in;
      res_slot_ff <= res_slot_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   bst_ram #(.WIDTH(KW), .DEPTH(S)) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_we),
      .wr_addr (tree_waddr),
      .wr_data (tree_wdata),
      .rd_addr (tree_raddr),
      .rd_data (tree_rd)
   );

   bst_ram #(.WIDTH(KW), .DEPTH(S)) u_scratch_ram (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (cnt_ff[IW-1:0]),
      .wr_data (tree_rd),
      .rd_addr (j_ff[IW-1:0]),
      .rd_data (scr_rd)
   );

endmodule

FILE: src/bst_controller.sv
module bst_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bst_pkg::bst_stat_type stat,
   output bst_pkg::bst_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHK     = 4'd1;
   localparam logic [3:0] S_CMP     = 4'd2;
   localparam logic [3:0] S_REM     = 4'd3;
   localparam logic [3:0] S_SUCC    = 4'd4;
   localparam logic [3:0] S_SUCC_CP = 4'd5;
   localparam logic [3:0] S_GATH    = 4'd6;
   localparam logic [3:0] S_GATH_WR = 4'd7;
   localparam logic [3:0] S_CLIMB   = 4'd8;
   localparam logic [3:0] S_REIN    = 4'd9;
   localparam logic [3:0] S_REIN_LD = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rein_ff, rein_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_insert;

   assign is_insert = (stat.kind == bst_pkg::KIND_INSERT);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequence one request through walk, remove, gather and reinsert
   always_comb begin
      state_in     = state_ff;
      rein_in      = rein_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '{op: bst_pkg::OP_NONE, set_res: 1'b0,
                       res_status: bst_pkg::ST_MISS, res_node: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = bst_pkg::OP_LOAD;
               rein_in  = 1'b0;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (!rein_ff && !is_insert && stat.kind != bst_pkg::KIND_SEARCH &&
                stat.kind != bst_pkg::KIND_REMOVE) begin
               cmd.set_res = 1'b1;
               state_in    = S_DONE;
            end else if (stat.node_oob) begin
               if (rein_ff) begin
                  state_in = S_REIN;
               end else begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = is_insert ? bst_pkg::ST_FULL : bst_pkg::ST_MISS;
                  state_in       = S_DONE;
               end
            end else if (!stat.node_p) begin
               if (rein_ff) begin
                  cmd.op   = bst_pkg::OP_PLACE;
                  state_in = S_REIN;
               end else if (is_insert) begin
                  cmd.op         = bst_pkg::OP_PLACE;
                  cmd.set_res    = 1'b1;
                  cmd.res_status = bst_pkg::ST_OK;
                  cmd.res_node   = 1'b1;
                  state_in       = S_DONE;
               end else begin
                  cmd.set_res = 1'b1;
                  state_in    = S_DONE;
               end
            end else begin
               cmd.op   = bst_pkg::OP_RD_NODE;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.key_eq) begin
               if (rein_ff) begin
                  state_in = S_REIN;
               end else begin
                  cmd.set_res    = 1'b1;
                  cmd.res_node   = 1'b1;
                  cmd.res_status = is_insert ? bst_pkg::ST_DUP : bst_pkg::ST_OK;
                  state_in = (stat.kind == bst_pkg::KIND_REMOVE) ? S_REM : S_DONE;
               end
            end else begin
               cmd.op   = bst_pkg::OP_DESCEND;
               state_in = S_CHK;
            end
         end
         S_REM: begin
            cmd.op = bst_pkg::OP_REM_CLEAR;
            if (stat.n_right_p) begin
               state_in = S_SUCC;
            end else if (stat.n_left_p) begin
               state_in = S_GATH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SUCC: begin
            if (stat.s_left_p) begin
               cmd.op = bst_pkg::OP_SUCC_LEFT;
            end else begin
               cmd.op   = bst_pkg::OP_RD_S;
               state_in = S_SUCC_CP;
            end
         end
         S_SUCC_CP: begin
            cmd.op   = bst_pkg::OP_SUCC_COPY;
            state_in = S_GATH;
         end
         S_GATH: begin
            cmd.op   = bst_pkg::OP_RD_G;
            state_in = S_GATH_WR;
         end
         S_GATH_WR: begin
            cmd.op = bst_pkg::OP_GATH_WR;
            if (stat.g_left_p || stat.g_right_p) begin
               state_in = S_GATH;
            end else if (stat.g_is_root) begin
               rein_in  = 1'b1;
               state_in = S_REIN;
            end else begin
               state_in = S_CLIMB;
            end
         end
         S_CLIMB: begin
            if (stat.g_is_root) begin
               rein_in  = 1'b1;
               state_in = S_REIN;
            end else begin
               cmd.op = bst_pkg::OP_CLIMB;
               if (stat.g_sib_p) begin
                  state_in = S_GATH;
               end
            end
         end
         S_REIN: begin
            if (stat.j_done) begin
               rein_in  = 1'b0;
               state_in = S_DONE;
            end else begin
               cmd.op   = bst_pkg::OP_RD_J;
               state_in = S_REIN_LD;
            end
         end
         S_REIN_LD: begin
            cmd.op   = bst_pkg::OP_REIN_LD;
            state_in = S_CHK;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = bst_pkg::OP_RSP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rein_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rein_ff      <= rein_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/implicit_array_bst_engine_unit.sv
// Insert and search walk the tree level by level, checking presence and then comparing keys;
// a remove adds the successor walk, a gather of the subtree keys into scratch memory with
// climbs, and a full reinsertion walk per gathered key.
// Throughput: one request at a time, set by the walk over the key memory's one read port.
// Reset: presence bits clear; key and scratch memories are not cleared.
module implicit_array_bst_engine_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bst_pkg::bst_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bst_pkg::bst_rsp_type rsp_data
);

   bst_pkg::bst_cmd_type  cmd;
   bst_pkg::bst_stat_type stat;

   bst_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bst_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
